// ----- rtl/ffaa_pkg.sv -----
// Shared types and constants for the first-fit arena allocator.
// No dependencies; used by every module of the block.
package ffaa_pkg;

  localparam int DEF_MAX_BLOCKS      = 64;
  localparam int DEF_MAX_ARENA_PAGES = 16384;

  localparam int ADDR_W      = 48;
  localparam int BYTES_W     = 32;
  localparam int CFG_PAGES_W = 15;
  localparam int STAT_W      = 2;
  localparam int PAGE_SHIFT  = 12;
  localparam int HDR_BYTES   = 64;
  localparam int PAGE_BYTES  = 4096;
  // ceil((bytes + 64) / 4096) fits in this many bits for a 32-bit byte count
  localparam int NEED_W      = BYTES_W + 1 - PAGE_SHIFT;
  localparam int IN_DATA_W   = 80;
  localparam int CFG_DATA_W  = 48;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic REG_ARENA_BASE  = 1'b0;
  localparam logic REG_ARENA_PAGES = 1'b1;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_RD_IDX,
    DP_NEXT,
    DP_TAKE,
    DP_SPLIT_START,
    DP_SH_RD,
    DP_SH_WR,
    DP_SP_W1,
    DP_SP_W0,
    DP_F_CLR,
    DP_M_STEP,
    DP_M_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              res_we;
    logic [STAT_W-1:0] res_status;
    logic              res_grant;
  } dp_cmd_t;

  typedef struct packed {
    logic in_alloc_bad;
    logic in_addr_zero;
    logic arena_unset;
    logic idx_end;
    logic fit;
    logic split_ok;
    logic shift_more;
    logic match;
  } dp_stat_t;

endpackage

// ----- rtl/first_fit_arena_allocator.sv -----
// First-fit arena allocator: top level joining controller and datapath.
// Each pass (search, free lookup, split shift, merge) visits a table entry in a read state
// followed by a check or write state; the block handles one item at a time.
// The table read data is registered, so each entry's read and use fall in separate states.
// Reset (synchronous, rst_n low): arena unset, table holds one block, no result pending.
// A result may wait on out_ while the next beat is taken on in_.
module first_fit_arena_allocator #(
  parameter int MAX_BLOCKS      = ffaa_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_ARENA_PAGES = ffaa_pkg::DEF_MAX_ARENA_PAGES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ffaa_pkg::IN_DATA_W-1:0]  in_tdata,   // byte_count[31:0], address[79:32]
  input  logic                            in_tuser,   // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ffaa_pkg::ADDR_W-1:0]     out_tdata,  // granted_address[47:0]
  output logic [ffaa_pkg::STAT_W-1:0]     out_tuser,  // status[1:0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [ffaa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffaa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffaa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_ready  (cfg_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ffaa_datapath #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_ARENA_PAGES (MAX_ARENA_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ----- rtl/ffaa_datapath.sv -----
// Datapath: block table memory, scan counters, offset and address arithmetic.
// Depends on ffaa_pkg; driven by ffaa_ctrl through dp_cmd_t.
module ffaa_datapath #(
  parameter int MAX_BLOCKS      = ffaa_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_ARENA_PAGES = ffaa_pkg::DEF_MAX_ARENA_PAGES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ffaa_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ffaa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ffaa_pkg::dp_cmd_t                   cmd,
  output ffaa_pkg::dp_stat_t                  stat,
  output logic [ffaa_pkg::ADDR_W-1:0]         out_tdata,
  output logic [ffaa_pkg::STAT_W-1:0]         out_tuser
);
  import ffaa_pkg::*;

  localparam int PW   = $clog2(MAX_ARENA_PAGES + 1);
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = ((PW > NEED_W) ? PW : NEED_W) + 1;

  logic [PW:0]         mem [MAX_BLOCKS];
  logic [PW:0]         q_r;
  logic                we, re;
  logic [IW-1:0]       wa, ra;
  logic [PW:0]         wd;

  logic [ADDR_W-1:0]   base_r;
  logic [PW-1:0]       arena_r;
  logic [CW-1:0]       total_r, idx_r, k_r, wr_r;
  logic [PW-1:0]       off_r, rem_r;
  logic [PW:0]         pend_r;
  logic                hp_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [NEED_W-1:0]   need_r;

  logic [PW-1:0]       q_pg;
  logic                q_busy;
  logic [BYTES_W:0]    need_sum;
  logic [ADDR_W-1:0]   uaddr;
  logic [CW-1:0]       idx_p1, k_m1;
  logic                mergeable;
  logic [PW-1:0]       pages_sat;

  assign q_pg   = q_r[PW-1:0];
  assign q_busy = q_r[PW];
  assign need_sum = {1'b0, in_tdata[BYTES_W-1:0]} + (BYTES_W+1)'(HDR_BYTES + PAGE_BYTES - 1);
  assign uaddr  = base_r + (ADDR_W'(off_r) << PAGE_SHIFT) + ADDR_W'(HDR_BYTES);
  assign idx_p1 = idx_r + CW'(1);
  assign k_m1   = k_r - CW'(1);
  assign mergeable = hp_r && !pend_r[PW] && !q_busy;

  always_comb begin
    if (32'(cfg_data[CFG_PAGES_W-1:0]) > 32'(MAX_ARENA_PAGES)) begin
      pages_sat = PW'(MAX_ARENA_PAGES);
    end else begin
      pages_sat = PW'(cfg_data[CFG_PAGES_W-1:0]);
    end
  end

  assign stat.in_alloc_bad = (arena_r == '0) || (in_tdata[BYTES_W-1:0] == '0);
  assign stat.in_addr_zero = (in_tdata[BYTES_W +: ADDR_W] == '0);
  assign stat.arena_unset  = (arena_r == '0);
  assign stat.idx_end      = (idx_r >= total_r);
  assign stat.fit          = !q_busy && (CMPW'(q_pg) >= CMPW'(need_r));
  assign stat.split_ok     = (CMPW'(q_pg) >= CMPW'(need_r) + CMPW'(2)) &&
                             (total_r < CW'(MAX_BLOCKS));
  assign stat.shift_more   = (k_r > idx_p1);
  assign stat.match        = (uaddr == addr_r);

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = idx_r[IW-1:0];
    ra = idx_r[IW-1:0];
    wd = q_r;
    case (cmd.op)
      DP_RD_IDX: re = 1'b1;
      DP_TAKE: begin
        we = 1'b1;
        wd = {1'b1, q_pg};
      end
      DP_SH_RD: begin
        re = 1'b1;
        ra = k_m1[IW-1:0];
      end
      DP_SH_WR: begin
        we = 1'b1;
        wa = k_r[IW-1:0];
      end
      DP_SP_W1: begin
        we = 1'b1;
        wa = idx_p1[IW-1:0];
        wd = {1'b0, rem_r};
      end
      DP_SP_W0: begin
        we = 1'b1;
        wd = {1'b1, PW'(need_r)};
      end
      DP_F_CLR: begin
        we = 1'b1;
        wd = {1'b0, q_pg};
      end
      DP_M_STEP: begin
        we = hp_r && !mergeable;
        wa = wr_r[IW-1:0];
        wd = pend_r;
      end
      DP_M_FLUSH: begin
        we = 1'b1;
        wa = wr_r[IW-1:0];
        wd = pend_r;
      end
      default: ;
    endcase
    if (cfg_we && cfg_index == REG_ARENA_PAGES) begin
      we = 1'b1;
      wa = '0;
      wd = {1'b0, pages_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      arena_r <= '0;
      total_r <= CW'(1);
      hp_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ARENA_BASE) begin
          base_r <= cfg_data;
        end else begin
          arena_r <= pages_sat;
          total_r <= CW'(1);
        end
      end
      case (cmd.op)
        DP_SP_W0:   total_r <= total_r + CW'(1);
        DP_F_CLR:   hp_r <= 1'b0;
        DP_M_STEP:  hp_r <= 1'b1;
        DP_M_FLUSH: total_r <= wr_r + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        addr_r <= in_tdata[BYTES_W +: ADDR_W];
        need_r <= need_sum[BYTES_W:PAGE_SHIFT];
        idx_r  <= '0;
        off_r  <= '0;
      end
      DP_NEXT: begin
        off_r <= off_r + q_pg;
        idx_r <= idx_p1;
      end
      DP_SPLIT_START: begin
        k_r   <= total_r;
        rem_r <= q_pg - PW'(need_r);
      end
      DP_SH_WR: k_r <= k_m1;
      DP_F_CLR: begin
        idx_r <= '0;
        wr_r  <= '0;
      end
      DP_M_STEP: begin
        idx_r <= idx_p1;
        if (mergeable) begin
          pend_r <= {pend_r[PW], pend_r[PW-1:0] + q_pg};
        end else begin
          if (hp_r) begin
            wr_r <= wr_r + CW'(1);
          end
          pend_r <= q_r;
        end
      end
      default: ;
    endcase
    if (cmd.res_we) begin
      out_tdata <= cmd.res_grant ? uaddr : '0;
      out_tuser <= cmd.res_status;
    end
  end

endmodule

// ----- rtl/ffaa_ctrl.sv -----
// Controller: sequences search, split shift, free lookup and merge passes.
// Depends on ffaa_pkg; commands ffaa_datapath and owns the handshakes.
module ffaa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic               cfg_ready,
  input  ffaa_pkg::dp_stat_t stat,
  output ffaa_pkg::dp_cmd_t  cmd
);
  import ffaa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_SH_RD, S_SH_WR, S_SP_W1, S_SP_W0,
    S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_M_FL, S_RES
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              res_grant_r, res_grant_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    res_stat_nxt   = res_stat_r;
    res_grant_nxt  = res_grant_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmd.op         = DP_NONE;
    cmd.res_we     = 1'b0;
    cmd.res_status = res_stat_r;
    cmd.res_grant  = res_grant_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op        = DP_LOAD;
          res_grant_nxt = 1'b0;
          state_nxt     = S_RES;
          if (in_tuser == FUNC_ALLOC) begin
            res_stat_nxt = STAT_NO_SPACE;
            if (!stat.in_alloc_bad) begin
              state_nxt = S_A_RD;
            end
          end else if (stat.in_addr_zero) begin
            res_stat_nxt = STAT_OK;
          end else if (stat.arena_unset) begin
            res_stat_nxt = STAT_NO_SPACE;
          end else begin
            res_stat_nxt = STAT_BAD_FREE;
            state_nxt    = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_RES;
        end else begin
          cmd.op    = DP_RD_IDX;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (stat.fit) begin
          res_stat_nxt  = STAT_OK;
          res_grant_nxt = 1'b1;
          if (stat.split_ok) begin
            cmd.op    = DP_SPLIT_START;
            state_nxt = S_SH_RD;
          end else begin
            cmd.op    = DP_TAKE;
            state_nxt = S_RES;
          end
        end else begin
          cmd.op    = DP_NEXT;
          state_nxt = S_A_RD;
        end
      end
      S_SH_RD: begin
        if (stat.shift_more) begin
          cmd.op    = DP_SH_RD;
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_SP_W1;
        end
      end
      S_SH_WR: begin
        cmd.op    = DP_SH_WR;
        state_nxt = S_SH_RD;
      end
      S_SP_W1: begin
        cmd.op    = DP_SP_W1;
        state_nxt = S_SP_W0;
      end
      S_SP_W0: begin
        cmd.op    = DP_SP_W0;
        state_nxt = S_RES;
      end
      S_F_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_RES;
        end else begin
          cmd.op    = DP_RD_IDX;
          state_nxt = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (stat.match) begin
          cmd.op       = DP_F_CLR;
          res_stat_nxt = STAT_OK;
          state_nxt    = S_M_RD;
        end else begin
          cmd.op    = DP_NEXT;
          state_nxt = S_F_RD;
        end
      end
      S_M_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_M_FL;
        end else begin
          cmd.op    = DP_RD_IDX;
          state_nxt = S_M_CHK;
        end
      end
      S_M_CHK: begin
        cmd.op    = DP_M_STEP;
        state_nxt = S_M_RD;
      end
      S_M_FL: begin
        cmd.op    = DP_M_FLUSH;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_we    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      res_stat_r  <= STAT_OK;
      res_grant_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_stat_r  <= res_stat_nxt;
      res_grant_r <= res_grant_nxt;
    end
  end

endmodule

// ----- rtl/ffaa_checker.sv -----
// Port-level checks for first_fit_arena_allocator, attached by bind.
// Depends on ffaa_pkg for field widths and status codes.
module ffaa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ffaa_pkg::ADDR_W-1:0]     out_tdata,
  input logic [ffaa_pkg::STAT_W-1:0]     out_tuser,
  input logic                            cfg_ready
);
  import ffaa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tdata == '0)
    else $error("nonzero address with failure status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !cfg_ready)
    else $error("new beat taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == STAT_OK || out_tuser == STAT_NO_SPACE ||
                   out_tuser == STAT_BAD_FREE)
    else $error("undefined status code");

endmodule

bind first_fit_arena_allocator ffaa_checker u_ffaa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for first_fit_arena_allocator: directed and random
// allocate/free beats against an in-bench model of the block table.
// Depends on ffaa_pkg and the allocator RTL.
import ffaa_pkg::*;

typedef struct {
  logic [ADDR_W-1:0] grant;
  logic [STAT_W-1:0] status;
} alloc_result_t;

class arena_scoreboard;
  logic [ADDR_W-1:0]      base;
  logic [CFG_PAGES_W-1:0] pages;
  int unsigned            blk_pages [DEF_MAX_BLOCKS];
  bit                     blk_busy  [DEF_MAX_BLOCKS];
  int unsigned            blk_total;
  alloc_result_t          pending_q [$];
  logic [ADDR_W-1:0]      live_q [$];
  int                     errors, grants, frees, results;

  function new();
    base = '0;
    pages = '0;
    clear_table();
  endfunction

  function void clear_table();
    for (int i = 0; i < DEF_MAX_BLOCKS; i++) begin
      blk_pages[i] = 0;
      blk_busy[i] = 0;
    end
    blk_pages[0] = pages;
    blk_total = 1;
    live_q.delete();
  endfunction

  function logic [ADDR_W-1:0] user_addr(longint unsigned off);
    longint unsigned a;
    a = base + off * PAGE_BYTES + HDR_BYTES;
    return a[ADDR_W-1:0];
  endfunction

  function void write_reg(logic idx, logic [CFG_DATA_W-1:0] v);
    int unsigned p;
    if (idx == REG_ARENA_BASE) begin
      base = v[ADDR_W-1:0];
    end else begin
      p = v[CFG_PAGES_W-1:0];
      if (p > DEF_MAX_ARENA_PAGES) p = DEF_MAX_ARENA_PAGES;
      pages = p;
      clear_table();
    end
  endfunction

  function void merge_free();
    int unsigned wr;
    wr = 0;
    for (int rd = 0; rd < blk_total; rd++) begin
      if (wr > 0 && !blk_busy[wr-1] && !blk_busy[rd]) begin
        blk_pages[wr-1] += blk_pages[rd];
      end else begin
        blk_pages[wr] = blk_pages[rd];
        blk_busy[wr] = blk_busy[rd];
        wr++;
      end
    end
    for (int rd = wr; rd < DEF_MAX_BLOCKS; rd++) begin
      blk_pages[rd] = 0;
      blk_busy[rd] = 0;
    end
    blk_total = (wr != 0) ? wr : 1;
  endfunction

  function void note_input(logic func, logic [BYTES_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    longint unsigned need, off;
    r.grant = '0;
    r.status = STAT_OK;
    off = 0;
    if (func == FUNC_ALLOC) begin
      r.status = STAT_NO_SPACE;
      if (pages != 0 && nbytes != 0) begin
        need = (longint'(nbytes) + HDR_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
        for (int i = 0; i < blk_total; i++) begin
          if (!blk_busy[i] && blk_pages[i] >= need) begin
            if (blk_pages[i] >= need + 2 && blk_total < DEF_MAX_BLOCKS) begin
              for (int k = blk_total; k > i + 1; k--) begin
                blk_pages[k] = blk_pages[k-1];
                blk_busy[k] = blk_busy[k-1];
              end
              blk_pages[i+1] = blk_pages[i] - 32'(need);
              blk_busy[i+1] = 0;
              blk_pages[i] = 32'(need);
              blk_total++;
            end
            blk_busy[i] = 1;
            r.grant = user_addr(off);
            r.status = STAT_OK;
            live_q.push_back(r.grant);
            grants++;
            break;
          end
          off += blk_pages[i];
        end
      end
    end else if (addr == 0) begin
      r.status = STAT_OK;
    end else if (pages == 0) begin
      r.status = STAT_NO_SPACE;
    end else begin
      r.status = STAT_BAD_FREE;
      for (int i = 0; i < blk_total; i++) begin
        if (user_addr(off) == addr) begin
          blk_busy[i] = 0;
          r.status = STAT_OK;
          break;
        end
        off += blk_pages[i];
      end
      if (r.status == STAT_OK) begin
        merge_free();
        frees++;
        foreach (live_q[j]) if (live_q[j] == addr) begin
          live_q.delete(j);
          break;
        end
      end
    end
    pending_q.push_back(r);
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(logic [ADDR_W-1:0] grant, logic [STAT_W-1:0] status);
    alloc_result_t r;
    results++;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected beat grant=%h status=%0d", grant, status));
      return;
    end
    r = pending_q.pop_front();
    if (grant !== r.grant)
      report($sformatf("grant %h, want %h", grant, r.grant));
    if (status !== r.status)
      report($sformatf("status %0d, want %0d", status, r.status));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid, out_tready;
  logic [ADDR_W-1:0]     out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_valid, cfg_ready, cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arena_scoreboard sb;
  int in_idle, out_stall, items;

  first_fit_arena_allocator uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk) if (rst_n) begin
    if (in_tvalid && in_tready)
      sb.note_input(in_tuser, in_tdata[BYTES_W-1:0], in_tdata[IN_DATA_W-1:BYTES_W]);
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_stall);

  task automatic send(logic func, logic [BYTES_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < in_idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {addr, nbytes};
    do @(posedge clk); while (!in_tready);
    items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setup();
    int unsigned sel;
    logic [CFG_DATA_W-1:0] b;
    sel = $urandom_range(3);
    b = (sel == 0) ? '0 : (sel == 1) ? {CFG_DATA_W{1'b1}} :
        CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_ARENA_BASE, b);
    case ($urandom_range(7))
      0: write_reg(REG_ARENA_PAGES, 1);
      1: write_reg(REG_ARENA_PAGES, 3);
      2: write_reg(REG_ARENA_PAGES, DEF_MAX_ARENA_PAGES);
      3: write_reg(REG_ARENA_PAGES, 15'h7fff);
      4: write_reg(REG_ARENA_PAGES, $urandom_range(DEF_MAX_ARENA_PAGES, 1));
      default: write_reg(REG_ARENA_PAGES, $urandom_range(300, 20));
    endcase
  endtask

  task automatic random_item();
    int unsigned r;
    logic [BYTES_W-1:0] nb;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    if (r < 55 || sb.live_q.size() == 0) begin
      case ($urandom_range(9))
        0: nb = $urandom;
        1: nb = $urandom_range(20 * PAGE_BYTES);
        default: nb = $urandom_range(3 * PAGE_BYTES);
      endcase
      send(FUNC_ALLOC, nb, ADDR_W'({$urandom, $urandom}));
    end else begin
      a = sb.live_q[$urandom_range(sb.live_q.size() - 1)];
      if (r >= 94) a = ADDR_W'({$urandom, $urandom});
      else if (r >= 90) a = a + PAGE_BYTES;
      else if (r == 89) a = '0;
      send(FUNC_FREE, $urandom, a);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] g;
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = FUNC_ALLOC;
    cfg_valid = 0;
    cfg_index = REG_ARENA_BASE;
    cfg_data = '0;
    out_tready = 1;
    in_idle = 0;
    out_stall = 0;
    items = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // not set up
    send(FUNC_ALLOC, 100, '0);
    send(FUNC_FREE, 0, 48'h1040);
    send(FUNC_FREE, 0, '0);
    write_reg(REG_ARENA_BASE, {CFG_DATA_W{1'b1}});
    write_reg(REG_ARENA_PAGES, 4);
    send(FUNC_ALLOC, 0, '0);
    send(FUNC_ALLOC, 32'hffff_ffff, '0);
    send(FUNC_ALLOC, PAGE_BYTES - HDR_BYTES, '0);
    send(FUNC_ALLOC, PAGE_BYTES - HDR_BYTES + 1, '0);
    send(FUNC_ALLOC, 1, '0);
    send(FUNC_ALLOC, 1, '0);
    drain();
    g = sb.user_addr(0);
    send(FUNC_FREE, 0, g);
    send(FUNC_FREE, 0, g);
    send(FUNC_FREE, 0, g + 1);
    send(FUNC_FREE, 0, {ADDR_W{1'b1}});
    write_reg(REG_ARENA_PAGES, 15'h7fff);
    write_reg(REG_ARENA_BASE, '0);
    send(FUNC_ALLOC, 32'hffff_ffff, '0);
    send(FUNC_ALLOC, (DEF_MAX_ARENA_PAGES - 1) * PAGE_BYTES, '0);
    write_reg(REG_ARENA_PAGES, 70);
    // fill the table so the last grant comes out whole and the beats after it find no space
    repeat (66) send(FUNC_ALLOC, 1, '0);
    write_reg(REG_ARENA_PAGES, 0);
    send(FUNC_ALLOC, 1, '0);

    for (int ph = 0; ph < 4; ph++) begin
      in_idle   = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 78) : 0;
      out_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 38 : 78) : 0;
      for (int seg = 0; seg < 4; seg++) begin
        random_setup();
        repeat (70) random_item();
      end
    end
    drain();
    repeat (400) @(posedge clk);

    $display("%0d beats sent over 4 handshake phases: %0d grants, %0d frees, %0d results",
             items, sb.grants, sb.frees, sb.results);
    $display("%0d mismatches, %0d results still pending", sb.errors, sb.pending_q.size());
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
